/* hdl/bst_pkg.sv */
// Shared types, constants and codes of the binary search table unit.
package bst_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = $clog2(TABLE_DEPTH) + 1;
    localparam int DATA_W      = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [0:0] REG_TABLE_LENGTH = 1'b0;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic [9:0]               entry_index;
        logic signed [31:0]       entry_value;
        logic signed [31:0]       search_key;
    } t_in_item;

    typedef struct packed {
        logic                     found;
        logic [9:0]               position;
    } t_out_item;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SEARCH = 1'b1
    } t_op;

    typedef struct packed {
        t_op                      op;
        logic [IDX_W-1:0]         addr;
        logic signed [DATA_W-1:0] data;
        logic signed [LEN_W:0]    last;
    } t_cmd;

    typedef struct packed {
        logic                     pop;
        logic                     busy;
    } t_eng_status;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PROBE = 4'b0010,
        S_CMP   = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

endpackage

/* hdl/bst_front.sv */
// Front end: accepts input transactions and turns them into queue commands.
module bst_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  bst_pkg::t_in_item      i_in_item,
    input  logic [bst_pkg::LEN_W-1:0] i_table_length,
    output logic                   o_push,
    output bst_pkg::t_cmd          o_cmd,
    input  logic                   i_full
);

    logic                           accept;
    logic                           in_range;
    logic [bst_pkg::LEN_W-1:0]      len_sat;
    logic [bst_pkg::LEN_W-1:0]      depth_len;

    assign depth_len = bst_pkg::LEN_W'(bst_pkg::TABLE_DEPTH);
    assign len_sat   = (i_table_length > depth_len) ? depth_len : i_table_length;
    assign in_range  = (32'(i_in_item.entry_index) < bst_pkg::TABLE_DEPTH);

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;

    always_comb begin
        o_cmd.last = $signed({1'b0, len_sat}) - (bst_pkg::LEN_W+1)'(1);
        if (i_in_item.mode == bst_pkg::MODE_SEARCH) begin
            o_cmd.op   = bst_pkg::OP_SEARCH;
            o_cmd.addr = '0;
            o_cmd.data = i_in_item.search_key;
        end else begin
            o_cmd.op   = bst_pkg::OP_WRITE;
            o_cmd.addr = i_in_item.entry_index[bst_pkg::IDX_W-1:0];
            o_cmd.data = i_in_item.entry_value;
        end
    end

    // drop writes beyond the table
    assign o_push = accept && (i_in_item.mode == bst_pkg::MODE_SEARCH || in_range);

endmodule

/* hdl/bst_queue.sv */
// Short command queue between the front end and the search engine.
module bst_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bst_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output bst_pkg::t_cmd o_cmd
);

    bst_pkg::t_cmd                 r_entries [bst_pkg::QUEUE_DEPTH];
    logic [bst_pkg::QPTR_W-1:0]    r_wptr, n_wptr;
    logic [bst_pkg::QPTR_W-1:0]    r_rptr, n_rptr;
    logic [bst_pkg::QPTR_W:0]      r_count, n_count;
    logic                          do_push;
    logic                          do_pop;

    assign o_full  = (r_count == (bst_pkg::QPTR_W+1)'(bst_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_entries[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (32'(r_wptr) == bst_pkg::QUEUE_DEPTH - 1) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (32'(r_rptr) == bst_pkg::QUEUE_DEPTH - 1) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entries[r_wptr] <= i_cmd;
        end
    end

endmodule

/* hdl/bst_engine.sv */
// Back end: table memory, binary search sequencer and result register.
module bst_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  bst_pkg::t_cmd        i_cmd,
    output bst_pkg::t_eng_status o_status,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output bst_pkg::t_out_item   o_out_item
);

    logic signed [bst_pkg::DATA_W-1:0] r_mem [bst_pkg::TABLE_DEPTH];
    logic signed [bst_pkg::DATA_W-1:0] r_rdata;
    logic signed [bst_pkg::DATA_W-1:0] r_key, n_key;
    logic signed [bst_pkg::LEN_W:0]    r_lo, n_lo;
    logic signed [bst_pkg::LEN_W:0]    r_hi, n_hi;
    logic [bst_pkg::IDX_W-1:0]         r_mid, n_mid;
    logic signed [bst_pkg::LEN_W:0]    sum;
    logic signed [bst_pkg::LEN_W:0]    mid_ext;
    logic                              r_found, n_found;
    bst_pkg::t_state                   r_state, n_state;
    bst_pkg::t_out_item                r_out, n_out;
    logic                              r_out_valid, n_out_valid;
    logic                              pop;
    logic                              mem_we;
    logic                              out_free;

    assign sum      = r_lo + r_hi;
    assign mid_ext  = $signed({{(bst_pkg::LEN_W+1-bst_pkg::IDX_W){1'b0}}, r_mid});
    assign out_free = !r_out_valid || !i_out_stall;
    assign pop      = (r_state == bst_pkg::S_IDLE) && i_valid;
    assign mem_we   = pop && (i_cmd.op == bst_pkg::OP_WRITE);

    assign o_status.pop  = pop;
    assign o_status.busy = (r_state != bst_pkg::S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_out_item    = r_out;

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_found     = r_found;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            bst_pkg::S_IDLE: begin
                if (pop && i_cmd.op == bst_pkg::OP_SEARCH) begin
                    n_key   = i_cmd.data;
                    n_lo    = '0;
                    n_hi    = i_cmd.last;
                    n_found = 1'b0;
                    n_state = bst_pkg::S_PROBE;
                end
            end
            bst_pkg::S_PROBE: begin
                if (r_lo > r_hi) begin
                    n_state = bst_pkg::S_DONE;
                end else begin
                    n_mid   = sum[bst_pkg::IDX_W:1];
                    n_state = bst_pkg::S_CMP;
                end
            end
            bst_pkg::S_CMP: begin
                priority if (r_key < r_rdata) begin
                    n_hi    = mid_ext - (bst_pkg::LEN_W+1)'(1);
                    n_state = bst_pkg::S_PROBE;
                end else if (r_key > r_rdata) begin
                    n_lo    = mid_ext + (bst_pkg::LEN_W+1)'(1);
                    n_state = bst_pkg::S_PROBE;
                end else begin
                    n_found = 1'b1;
                    n_state = bst_pkg::S_DONE;
                end
            end
            bst_pkg::S_DONE: begin
                if (out_free) begin
                    n_out.found    = r_found;
                    n_out.position = r_found ? r_mid : '0;
                    n_out_valid    = 1'b1;
                    n_state        = bst_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bst_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bst_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_found <= n_found;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_cmd.addr] <= i_cmd.data;
        end
        r_rdata <= r_mem[n_mid];
    end

endmodule

/* hdl/binary_search_table_unit.sv */
// Top level of the binary search table unit: register port, front end, queue and engine.
// A write transaction stores one 32-bit entry and gives no result; a search transaction
// gives one result. Transactions pass the front end into a two-entry queue, so input is
// taken while the engine works or a result waits to be taken. The engine handles one
// command at a time: a write is stored in the table memory; a search runs probes, each a
// table memory read then a compare, until the key is found or the range is empty, and
// takes longer while the output is stalled. The table memory has no reset: search only
// entries already written. table_length (byte address 0) saturates at 1024; the user
// must write it only while the unit is idle, and the unit itself does not enforce this.
module binary_search_table_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bst_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bst_pkg::t_out_item            o_out_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bst_pkg::PADDR_W-1:0]   paddr,
    input  logic [bst_pkg::PDATA_W-1:0]   pwdata,
    output logic [bst_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [bst_pkg::LEN_W-1:0] r_table_length;
    logic                      cfg_we;
    logic                      push;
    logic                      q_full;
    logic                      q_valid;
    bst_pkg::t_cmd             front_cmd;
    bst_pkg::t_cmd             q_cmd;
    bst_pkg::t_eng_status      eng_status;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready
                    && (paddr[2:2] == bst_pkg::REG_TABLE_LENGTH);
    assign prdata = (paddr[2:2] == bst_pkg::REG_TABLE_LENGTH)
                    ? bst_pkg::PDATA_W'(r_table_length) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_length <= '0;
        end else if (cfg_we) begin
            r_table_length <= pwdata[bst_pkg::LEN_W-1:0];
        end
    end

    bst_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_item      (i_in_item),
        .i_table_length (r_table_length),
        .o_push         (push),
        .o_cmd          (front_cmd),
        .i_full         (q_full)
    );

    bst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (eng_status.pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    bst_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_cmd       (q_cmd),
        .o_status    (eng_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

`ifndef SYNTH
    a_pop_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_status.pop |-> q_valid && !eng_status.busy)
        else $error("engine popped an empty queue or while busy");

    a_miss_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.found |-> o_out_item.position == '0)
        else $error("miss result carries a non-zero position");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_we |=> r_table_length == $past(pwdata[bst_pkg::LEN_W-1:0]))
        else $error("table_length not updated by register write");
`endif

endmodule
